// File: hw/rtl/rne_pkg.sv
// shared types, constants and letter tables for the roman numeral encoder
package rne_pkg;

    // input and result widths
    localparam int YEAR_W    = 12;
    localparam int SYMBOL_W  = 7;
    localparam int DIGIT_W   = 4;
    localparam int NUM_PLACES = 4;
    localparam int PLACE_W   = $clog2(NUM_PLACES);
    localparam int LEN_W     = 3;
    localparam int POS_W     = 2;

    // largest year that has a numeral
    localparam logic [YEAR_W-1:0] YEAR_MAX = 12'd3999;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // places, thousands first
    localparam logic [PLACE_W-1:0] PLACE_THOU = 2'd0;
    localparam logic [PLACE_W-1:0] PLACE_HUND = 2'd1;
    localparam logic [PLACE_W-1:0] PLACE_TENS = 2'd2;
    localparam logic [PLACE_W-1:0] PLACE_ONES = 2'd3;

    // ascii codes of the letters
    localparam logic [SYMBOL_W-1:0] CHAR_I    = 7'h69;
    localparam logic [SYMBOL_W-1:0] CHAR_V    = 7'h76;
    localparam logic [SYMBOL_W-1:0] CHAR_X    = 7'h78;
    localparam logic [SYMBOL_W-1:0] CHAR_L    = 7'h6C;
    localparam logic [SYMBOL_W-1:0] CHAR_C    = 7'h63;
    localparam logic [SYMBOL_W-1:0] CHAR_D    = 7'h64;
    localparam logic [SYMBOL_W-1:0] CHAR_M    = 7'h6D;
    localparam logic [SYMBOL_W-1:0] CHAR_NONE = 7'h00;

    // which letter of a place is written
    typedef enum logic [1:0] {
        SEL_UNIT = 2'd0,
        SEL_FIVE = 2'd1,
        SEL_TEN  = 2'd2
    } sel_t;

    // one classified year as it sits in the queue
    typedef struct packed {
        logic                                err;
        logic [NUM_PLACES-1:0][DIGIT_W-1:0]  digit;
    } entry_t;

    // number of letters a decimal digit writes
    function automatic logic [LEN_W-1:0] digit_len(input logic [DIGIT_W-1:0] d);
        logic [LEN_W-1:0] len;
        case (d)
            4'd1, 4'd5:        len = 3'd1;
            4'd2, 4'd4, 4'd6,
            4'd9:              len = 3'd2;
            4'd3, 4'd7:        len = 3'd3;
            4'd8:              len = 3'd4;
            default:           len = 3'd0;
        endcase
        return len;
    endfunction

    // letter choice for position pos of digit d, subtractive rule
    function automatic sel_t digit_sel(input logic [DIGIT_W-1:0] d,
                                       input logic [POS_W-1:0] pos);
        sel_t sel;
        sel = SEL_UNIT;
        if (d inside {[4'd5:4'd8]})
        begin
            sel = (pos == 2'd0) ? SEL_FIVE : SEL_UNIT;
        end
        else if (d == 4'd4)
        begin
            sel = (pos == 2'd0) ? SEL_UNIT : SEL_FIVE;
        end
        else if (d == 4'd9)
        begin
            sel = (pos == 2'd0) ? SEL_UNIT : SEL_TEN;
        end
        return sel;
    endfunction

    // ascii letter of a place and choice
    function automatic logic [SYMBOL_W-1:0] place_letter(input logic [PLACE_W-1:0] place,
                                                        input sel_t sel);
        logic [SYMBOL_W-1:0] ch;
        case (place)
            PLACE_THOU: ch = CHAR_M;
            PLACE_HUND:
            begin
                case (sel)
                    SEL_UNIT: ch = CHAR_C;
                    SEL_FIVE: ch = CHAR_D;
                    default:  ch = CHAR_M;
                endcase
            end
            PLACE_TENS:
            begin
                case (sel)
                    SEL_UNIT: ch = CHAR_X;
                    SEL_FIVE: ch = CHAR_L;
                    default:  ch = CHAR_C;
                endcase
            end
            default:
            begin
                case (sel)
                    SEL_UNIT: ch = CHAR_I;
                    SEL_FIVE: ch = CHAR_V;
                    default:  ch = CHAR_X;
                endcase
            end
        endcase
        return ch;
    endfunction

endpackage

// File: hw/rtl/rne_front.sv
// front end: range check and split of the year into decimal digits
module rne_front (
    input  logic                        in_valid,
    input  logic [rne_pkg::YEAR_W-1:0]  year,
    input  logic                        q_full,
    output logic                        in_ready,
    output logic                        q_push,
    output rne_pkg::entry_t             q_wdata
);
    import rne_pkg::*;

    logic [1:0]           thou;
    logic [YEAR_W-1:0]    thou_sub;
    logic [YEAR_W-1:0]    rem1_full;
    logic [9:0]           rem1;
    logic [DIGIT_W-1:0]   hund;
    logic [9:0]           rem2_full;
    logic [6:0]           rem2;
    logic [DIGIT_W-1:0]   tens;
    logic [6:0]           ones_full;

    // take a transfer whenever the queue has room
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // thousands by compare, then strip them
    always_comb
    begin
        if (year >= 12'd3000)
        begin
            thou     = 2'd3;
            thou_sub = 12'd3000;
        end
        else if (year >= 12'd2000)
        begin
            thou     = 2'd2;
            thou_sub = 12'd2000;
        end
        else if (year >= 12'd1000)
        begin
            thou     = 2'd1;
            thou_sub = 12'd1000;
        end
        else
        begin
            thou     = 2'd0;
            thou_sub = 12'd0;
        end
        rem1_full = year - thou_sub;
        rem1      = rem1_full[9:0];
    end

    // hundreds by parallel compares against the multiples of 100
    always_comb
    begin
        hund = '0;
        for (int i = 1; i < 10; i++)
        begin
            if (rem1 >= 10'(i * 100))
            begin
                hund = DIGIT_W'(i);
            end
        end
        rem2_full = rem1 - 10'(hund) * 10'd100;
        rem2      = rem2_full[6:0];
    end

    // tens by parallel compares, ones are what is left
    always_comb
    begin
        tens = '0;
        for (int i = 1; i < 10; i++)
        begin
            if (rem2 >= 7'(i * 10))
            begin
                tens = DIGIT_W'(i);
            end
        end
        ones_full = rem2 - 7'(tens) * 7'd10;
    end

    // classified entry for the queue
    always_comb
    begin
        q_wdata.err               = (year == '0) || (year > YEAR_MAX);
        q_wdata.digit[PLACE_THOU] = {2'b00, thou};
        q_wdata.digit[PLACE_HUND] = hund;
        q_wdata.digit[PLACE_TENS] = tens;
        q_wdata.digit[PLACE_ONES] = ones_full[DIGIT_W-1:0];
    end

endmodule

// File: hw/rtl/rne_queue.sv
// short fifo of classified years between front and back
module rne_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rne_pkg::entry_t  wdata,
    input  logic             pop,
    output rne_pkg::entry_t  rdata,
    output logic             full,
    output logic             empty
);
    import rne_pkg::*;

    entry_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: hw/rtl/rne_back.sv
// back end: walks the digits of one entry and sends one letter per transfer
module rne_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  rne_pkg::entry_t               q_rdata,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rne_pkg::SYMBOL_W-1:0]  symbol,
    output logic                          last,
    output logic                          error
);
    import rne_pkg::*;

    logic                               busy_reg;
    logic                               busy_next;
    logic                               err_reg;
    logic                               err_next;
    logic [NUM_PLACES-1:0][DIGIT_W-1:0] digit_reg;
    logic [NUM_PLACES-1:0][DIGIT_W-1:0] digit_next;
    logic [PLACE_W-1:0]                 place_reg;
    logic [PLACE_W-1:0]                 place_next;
    logic [POS_W-1:0]                   pos_reg;
    logic [POS_W-1:0]                   pos_next;

    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [SYMBOL_W-1:0]                symbol_reg;
    logic                               last_reg;
    logic                               error_reg;

    logic [NUM_PLACES-1:0]              nz;
    logic [NUM_PLACES-1:0]              load_nz;
    logic [DIGIT_W-1:0]                 cur_digit;
    logic [LEN_W-1:0]                   cur_len;
    logic [SYMBOL_W-1:0]                cur_symbol;
    logic                               digit_done;
    logic                               has_later;
    logic [PLACE_W-1:0]                 later_place;
    logic [PLACE_W-1:0]                 first_place;
    logic                               cur_last;
    logic                               fire;
    logic                               load;

    // current letter and where the walk goes next
    always_comb
    begin
        for (int i = 0; i < NUM_PLACES; i++)
        begin
            nz[i]      = (digit_reg[i] != '0);
            load_nz[i] = (q_rdata.digit[i] != '0);
        end
        cur_digit  = digit_reg[place_reg];
        cur_len    = digit_len(cur_digit);
        cur_symbol = place_letter(place_reg, digit_sel(cur_digit, pos_reg));
        digit_done = ({1'b0, pos_reg} + 1'b1) == cur_len;

        // nearest nonzero place after the current one
        has_later   = 1'b0;
        later_place = place_reg;
        for (int i = NUM_PLACES - 1; i >= 0; i--)
        begin
            if (nz[i] && (PLACE_W'(i) > place_reg))
            begin
                has_later   = 1'b1;
                later_place = PLACE_W'(i);
            end
        end

        // first nonzero place of the entry at the queue head
        first_place = '0;
        for (int i = NUM_PLACES - 1; i >= 0; i--)
        begin
            if (load_nz[i])
            begin
                first_place = PLACE_W'(i);
            end
        end

        cur_last = err_reg || (digit_done && !has_later);
    end

    // a letter moves to the output register when it is free or being drained
    assign fire  = busy_reg && (!out_valid_reg || out_ready);
    assign load  = !q_empty && (!busy_reg || (fire && cur_last));
    assign q_pop = load;

    // walk state
    always_comb
    begin
        busy_next  = busy_reg;
        err_next   = err_reg;
        digit_next = digit_reg;
        place_next = place_reg;
        pos_next   = pos_reg;
        if (load)
        begin
            busy_next  = 1'b1;
            err_next   = q_rdata.err;
            digit_next = q_rdata.digit;
            place_next = first_place;
            pos_next   = '0;
        end
        else if (fire)
        begin
            if (cur_last)
            begin
                busy_next = 1'b0;
            end
            else if (digit_done)
            begin
                place_next = later_place;
                pos_next   = '0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // walk payload and result payload
    always_ff @(posedge clk)
    begin
        err_reg   <= err_next;
        digit_reg <= digit_next;
        place_reg <= place_next;
        pos_reg   <= pos_next;
        if (fire)
        begin
            symbol_reg <= err_reg ? CHAR_NONE : cur_symbol;
            last_reg   <= cur_last;
            error_reg  <= err_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign symbol    = symbol_reg;
    assign last      = last_reg;
    assign error     = error_reg;

endmodule

// File: hw/rtl/roman_numeral_encoder.sv
// top level of the roman numeral encoder
//
// Takes one binary year per transfer on the input channel (in_valid,
// in_ready, year) and sends its roman numeral in lower-case ascii on the
// output channel (out_valid, out_ready, symbol, last, error), one letter per
// transfer, thousands first, with last set on the final letter.
// A year of 0 or above 3999 gives a single transfer with symbol 0, last 1
// and error 1.
// The front splits the year into decimal digits in the cycle it is taken
// and writes it into a two-entry queue. The back walks the digits and puts
// one letter per cycle into the output register while the receiver takes
// them. The year is registered in the queue and then in the back's walk
// registers before its first letter reaches the output register. A numeral
// has 1 to 15 letters; the back's single letter register sets the rate. A
// queued year follows its predecessor's last letter with no gap.
// When the receiver stalls the output register holds, the back stops, and
// in_ready drops once the queue is full.
// Reset empties the queue, the back and the output register; nothing else
// is kept between years.
module roman_numeral_encoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rne_pkg::YEAR_W-1:0]    year,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rne_pkg::SYMBOL_W-1:0]  symbol,
    output logic                          last,
    output logic                          error
);
    import rne_pkg::*;

    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_empty;
    entry_t  q_wdata;
    entry_t  q_rdata;

    rne_front u_front (
        .in_valid (in_valid),
        .year     (year),
        .q_full   (q_full),
        .in_ready (in_ready),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    rne_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    rne_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .symbol    (symbol),
        .last      (last),
        .error     (error)
    );

    // an accepted year is in the queue on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !q_empty)
        else $error("accepted year missing from queue");

    // the back never reads an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");

    // an error result is a single letter-less transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> last && (symbol == CHAR_NONE))
        else $error("malformed error result");

    // a good result always carries a letter
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !error |-> (symbol != CHAR_NONE))
        else $error("empty letter on good result");

endmodule

// File: tb/sv/roman_numeral_encoder_test.sv
// self-checking testbench for the roman numeral encoder
module roman_numeral_encoder_test;

    import rne_pkg::*;

    // cycles with no transfer on either channel before the run is called hung
    localparam int QUIET_LIMIT = 2000;
    // cycles to wait after the last letter
    localparam int SETTLE_CYCLES = 10;
    // receiver hold-off long enough to fill the queue and stall the input
    localparam int HOLD_CYCLES = 80;
    localparam int RANDOM_PHASE_ITEMS = 100;

    // one expected letter of a numeral
    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                last;
        logic                error;
    } letter_t;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [YEAR_W-1:0]   year;
    logic                out_valid;
    logic                out_ready;
    logic [SYMBOL_W-1:0] symbol;
    logic                last;
    logic                error;

    letter_t expected_letters[$];
    letter_t next_letter;
    int      mismatch_count = 0;
    int      quiet_cycles = 0;
    int      sender_idle_pct = 0;
    int      receiver_stall_pct = 0;
    int      hold_left = 0;

    roman_numeral_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .year      (year),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .symbol    (symbol),
        .last      (last),
        .error     (error)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // expected letters of one year, subtractive rule per decimal place
    function automatic void predict_numeral(input logic [YEAR_W-1:0] y);
        logic [SYMBOL_W-1:0] chars[$];
        logic [SYMBOL_W-1:0] one_ch;
        logic [SYMBOL_W-1:0] five_ch;
        logic [SYMBOL_W-1:0] ten_ch;
        letter_t             item;
        int                  divisor;
        int                  digit;
        int                  place;
        int                  k;
        if (y == '0 || y > YEAR_MAX)
        begin
            item.symbol = CHAR_NONE;
            item.last   = 1'b1;
            item.error  = 1'b1;
            expected_letters.push_back(item);
            return;
        end
        divisor = 1000;
        for (place = 0; place < NUM_PLACES; place++)
        begin
            digit = (int'(y) / divisor) % 10;
            divisor = divisor / 10;
            case (place)
                PLACE_THOU:
                begin
                    one_ch = CHAR_M;
                    five_ch = CHAR_M;
                    ten_ch = CHAR_M;
                end
                PLACE_HUND:
                begin
                    one_ch = CHAR_C;
                    five_ch = CHAR_D;
                    ten_ch = CHAR_M;
                end
                PLACE_TENS:
                begin
                    one_ch = CHAR_X;
                    five_ch = CHAR_L;
                    ten_ch = CHAR_C;
                end
                default:
                begin
                    one_ch = CHAR_I;
                    five_ch = CHAR_V;
                    ten_ch = CHAR_X;
                end
            endcase
            if (digit == 9)
            begin
                chars.push_back(one_ch);
                chars.push_back(ten_ch);
            end
            else if (digit == 4)
            begin
                chars.push_back(one_ch);
                chars.push_back(five_ch);
            end
            else
            begin
                if (digit >= 5)
                    chars.push_back(five_ch);
                for (k = 0; k < digit % 5; k++)
                    chars.push_back(one_ch);
            end
        end
        for (k = 0; k < chars.size(); k++)
        begin
            item.symbol = chars[k];
            item.last   = (k == chars.size() - 1);
            item.error  = 1'b0;
            expected_letters.push_back(item);
        end
    endfunction

    // year whose lower three digits write three or four letters each
    function automatic logic [YEAR_W-1:0] long_year();
        int heavy[3] = '{3, 7, 8};
        return YEAR_W'($urandom_range(1, 3) * 1000 + heavy[$urandom_range(2)] * 100
                       + heavy[$urandom_range(2)] * 10 + heavy[$urandom_range(2)]);
    endfunction

    // mostly valid years, some long numerals, some out of range
    function automatic logic [YEAR_W-1:0] random_year();
        int roll;
        roll = $urandom_range(99);
        if (roll < 4)
            return '0;
        else if (roll < 10)
            return YEAR_W'($urandom_range(4095, int'(YEAR_MAX) + 1));
        else if (roll < 25)
            return long_year();
        else
            return YEAR_W'($urandom_range(1, int'(YEAR_MAX)));
    endfunction

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:
            begin
                sender_idle_pct = 52;
                receiver_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                sender_idle_pct = 0;
                receiver_stall_pct = 52;
            end
            IDLE_BOTH:
            begin
                sender_idle_pct = 27;
                receiver_stall_pct = 27;
            end
            default:
            begin
                sender_idle_pct = 0;
                receiver_stall_pct = 0;
            end
        endcase
    endtask

    // offer one year and return in the step of its transfer
    task automatic send_year(input logic [YEAR_W-1:0] y);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        year <= y;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_numeral(y);
    endtask

    // stop offering and wait until every expected letter has arrived
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_letters.size() != 0)
            @(posedge clk);
    endtask

    // range ends, fours and nines, fives and tens, zero digits, all-ones input
    task automatic test_directed();
        logic [YEAR_W-1:0] years[25] = '{
            12'd0, 12'd1, 12'd3999, 12'd4000, 12'd4095, 12'd3888,
            12'd4, 12'd9, 12'd40, 12'd90, 12'd400, 12'd900,
            12'd1000, 12'd2004, 12'd5, 12'd10, 12'd50, 12'd500,
            12'd1994, 12'd3444, 12'd2999, 12'd1666, 12'd2777, 12'd3010,
            12'd2048
        };
        set_idle(IDLE_NONE);
        foreach (years[i])
            send_year(years[i]);
    endtask

    // random years under each idling pattern
    task automatic test_random_flow();
        idle_mode_t modes[4] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
        foreach (modes[m])
        begin
            set_idle(modes[m]);
            repeat (RANDOM_PHASE_ITEMS)
                send_year(random_year());
        end
    endtask

    // receiver holds off while the sender keeps offering long numerals
    task automatic test_input_stall();
        set_idle(IDLE_NONE);
        hold_left = HOLD_CYCLES;
        repeat (15)
            send_year(long_year());
    endtask

    // sender waits for every letter before going on
    task automatic test_drain_pause();
        set_idle(IDLE_BOTH);
        repeat (5)
            send_year(random_year());
        wait_drained();
        repeat (5)
            send_year(random_year());
    endtask

    // receiver readiness, with random stalls and a counted hold-off
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // compare each output transfer with the oldest expected letter
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_letters.size() == 0)
            begin
                $display("%0t: unexpected letter symbol=%h last=%b error=%b",
                         $time, symbol, last, error);
                mismatch_count++;
            end
            else
            begin
                next_letter = expected_letters.pop_front();
                if (symbol !== next_letter.symbol)
                begin
                    $display("%0t: symbol expected %h actual %h",
                             $time, next_letter.symbol, symbol);
                    mismatch_count++;
                end
                if (last !== next_letter.last)
                begin
                    $display("%0t: last expected %b actual %b",
                             $time, next_letter.last, last);
                    mismatch_count++;
                end
                if (error !== next_letter.error)
                begin
                    $display("%0t: error expected %b actual %b",
                             $time, next_letter.error, error);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("roman_numeral_encoder verification failed");
            $finish;
        end
    end

    // reset, stimulus and verdict
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        year = '0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_flow();
        test_input_stall();
        test_drain_pause();
        in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("roman_numeral_encoder verification clean");
        else
            $display("roman_numeral_encoder verification failed");
        $finish;
    end

endmodule
